>>> sv/wsfd_pkg.sv
// Package for the WebSocket frame deframer: widths, opcodes and length limits.
package wsfd_pkg;

  // Largest payload length the block carries, in bits (16 to 64)
  localparam int unsigned LENGTH_BITS = 64;

  // Saturation limit for a decoded length
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  // Field widths
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned PLEN_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HCNT_W   = 4;

  // Packed widths of the output tdata (fin, opcode, masked, length, byte, unsupported)
  localparam int unsigned OUT_FIELDS_W = 1 + OPCODE_W + 1 + PLEN_W + BYTE_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Header constants
  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [7:0] LEN7_MASK   = 8'h7F;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [HCNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [HCNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [HCNT_W-1:0] KEY_BYTES   = 4'd4;

  // Supported opcodes
  localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
  localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
  localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
  localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Opcode outside text, binary, close and ping
  function automatic logic is_unsupported(input logic [OPCODE_W-1:0] op);
    logic res;
    case (op)
      OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING: res = 1'b0;
      default:                               res = 1'b1;
    endcase
    return res;
  endfunction

  // Clamp a decoded length to the configured length width
  function automatic logic [PLEN_W-1:0] sat_len(input logic [PLEN_W-1:0] len);
    logic [PLEN_W-1:0] res;
    res = ((len & ~LEN_MAX) != '0) ? LEN_MAX : len;
    return res;
  endfunction

endpackage

>>> sv/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: header parsing and payload unmasking, one byte per cycle unless stalled.
//
// Usage:
//   s_axis_* carries received stream bytes, one per transfer, frames back to back.
//   m_axis_* carries results. tuser is the kind: 0 for the header result, given
//   on the byte that completes the header; 1 for a payload byte, unmasked with the
//   rotating key byte. tlast marks the final result of a frame (the header result
//   when the payload is empty). Header bytes other than the last one give nothing.
//   Path: an accepted byte is held in the input register; its result is then
//   loaded into the output register, which drives m_axis_*.
//   Throughput: one byte per cycle unless stalled. The only path per byte is the
//   header/payload step between the input register and the output register
//   (a 64-bit length shift or decrement and compare).
//   Stall: when m_axis_tready is low with a result waiting, the input register
//   still takes one more byte; s_axis_tready drops once both registers are full.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   parser to the first header byte with all frame state cleared.
//   Lengths above the configured length width saturate; RSV bits are ignored.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] fin, [4:1] opcode, [5] masked, [69:6] payload_length,
  // [77:70] payload_byte, [78] unsupported, [79] zero
  output logic [wsfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] kind
  output logic        m_axis_tlast_o    // last
);

  typedef enum logic [2:0] {
    PH_B0,
    PH_B1,
    PH_EXT,
    PH_KEY,
    PH_PAY
  } phase_e;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  phase_e                              phase_q, phase_d;
  logic [wsfd_pkg::HCNT_W-1:0]         hcnt_q, hcnt_d;
  logic                                fin_q, fin_d;
  logic [wsfd_pkg::OPCODE_W-1:0]       opcode_q, opcode_d;
  logic                                mask_q, mask_d;
  logic [wsfd_pkg::PLEN_W-1:0]         len_q, len_d;
  logic [wsfd_pkg::KEY_W-1:0]          key_q, key_d;
  logic [wsfd_pkg::PLEN_W-1:0]         left_q, left_d;
  logic [1:0]                          kidx_q, kidx_d;

  // Output register
  logic                                out_valid_q;
  logic                                out_kind_q, out_last_q;
  logic                                out_fin_q, out_mask_q, out_unsup_q;
  logic [wsfd_pkg::OPCODE_W-1:0]       out_opcode_q;
  logic [wsfd_pkg::PLEN_W-1:0]         out_len_q;
  logic [wsfd_pkg::BYTE_W-1:0]         out_byte_q;

  // Step results
  logic                                res_valid;
  logic                                res_kind;
  logic                                res_last;
  logic [wsfd_pkg::BYTE_W-1:0]         res_byte;
  logic                                advance;
  logic                                step;
  logic [wsfd_pkg::PLEN_W-1:0]         fin_len;
  logic [wsfd_pkg::BYTE_W-1:0]         key_byte;
  logic [wsfd_pkg::HCNT_W-1:0]         hcnt_dec;
  logic [6:0]                          len7;

  // Handshake: the output register frees or drains, the input register follows
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign len7     = in_byte_q[6:0];
  assign hcnt_dec = (hcnt_q != '0) ? hcnt_q - 4'd1 : hcnt_q;

  // Key byte for the current payload position, first key byte in the top bits
  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // One parser step per byte
  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    key_d     = key_q;
    left_d    = left_q;
    kidx_d    = kidx_q;
    res_valid = 1'b0;
    res_kind  = wsfd_pkg::KIND_HEADER;
    res_last  = 1'b0;
    res_byte  = '0;
    fin_len   = len_q;

    unique case (phase_q)
      PH_B0: begin
        fin_d    = (in_byte_q & wsfd_pkg::FIN_BIT) != '0;
        opcode_d = in_byte_q[wsfd_pkg::OPCODE_W-1:0];
        mask_d   = 1'b0;
        key_d    = '0;
        len_d    = '0;
        phase_d  = PH_B1;
      end
      PH_B1: begin
        mask_d = (in_byte_q & wsfd_pkg::MASK_BIT) != '0;
        len_d  = '0;
        if (len7 == wsfd_pkg::LEN7_EXT16 || len7 == wsfd_pkg::LEN7_EXT64) begin
          hcnt_d  = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                   : wsfd_pkg::EXT64_BYTES;
          phase_d = PH_EXT;
        end else if (mask_d) begin
          len_d   = {{(wsfd_pkg::PLEN_W-7){1'b0}}, len7};
          hcnt_d  = wsfd_pkg::KEY_BYTES;
          phase_d = PH_KEY;
        end else begin
          fin_len   = wsfd_pkg::sat_len({{(wsfd_pkg::PLEN_W-7){1'b0}}, len7});
          res_valid = 1'b1;
        end
      end
      PH_EXT: begin
        len_d  = {len_q[wsfd_pkg::PLEN_W-9:0], in_byte_q};
        hcnt_d = hcnt_dec;
        if (hcnt_dec == '0) begin
          if (mask_q) begin
            hcnt_d  = wsfd_pkg::KEY_BYTES;
            phase_d = PH_KEY;
          end else begin
            fin_len   = wsfd_pkg::sat_len(len_d);
            res_valid = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d  = {key_q[wsfd_pkg::KEY_W-9:0], in_byte_q};
        hcnt_d = hcnt_dec;
        if (hcnt_dec == '0) begin
          fin_len   = wsfd_pkg::sat_len(len_q);
          res_valid = 1'b1;
        end
      end
      PH_PAY: begin
        kidx_d    = kidx_q + 2'd1;
        left_d    = (left_q != '0) ? left_q - 64'd1 : left_q;
        res_valid = 1'b1;
        res_kind  = wsfd_pkg::KIND_PAYLOAD;
        res_byte  = in_byte_q ^ key_byte;
        res_last  = (left_d == '0);
        if (res_last) begin
          phase_d = PH_B0;
        end
      end
      default: begin
        phase_d = PH_B0;
      end
    endcase

    // Header completion: load the payload counters and pick the next phase
    if (res_valid && res_kind == wsfd_pkg::KIND_HEADER) begin
      len_d    = fin_len;
      left_d   = fin_len;
      kidx_d   = '0;
      hcnt_d   = '0;
      res_last = (fin_len == '0);
      phase_d  = res_last ? PH_B0 : PH_PAY;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= '0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
      if (s_axis_tvalid_i) begin
        in_byte_q <= s_axis_tdata_i;
      end
    end
  end

  // Parser state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_B0;
      hcnt_q       <= '0;
      fin_q        <= 1'b0;
      opcode_q     <= '0;
      mask_q       <= 1'b0;
      len_q        <= '0;
      key_q        <= '0;
      left_q       <= '0;
      kidx_q       <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= 1'b0;
      out_last_q   <= 1'b0;
      out_fin_q    <= 1'b0;
      out_opcode_q <= '0;
      out_mask_q   <= 1'b0;
      out_len_q    <= '0;
      out_byte_q   <= '0;
      out_unsup_q  <= 1'b0;
    end else begin
      if (step) begin
        phase_q  <= phase_d;
        hcnt_q   <= hcnt_d;
        fin_q    <= fin_d;
        opcode_q <= opcode_d;
        mask_q   <= mask_d;
        len_q    <= len_d;
        key_q    <= key_d;
        left_q   <= left_d;
        kidx_q   <= kidx_d;
      end
      if (advance) begin
        out_valid_q <= step && res_valid;
      end
      if (step && res_valid) begin
        out_kind_q   <= res_kind;
        out_last_q   <= res_last;
        out_fin_q    <= fin_d;
        out_opcode_q <= opcode_d;
        out_mask_q   <= mask_d;
        out_len_q    <= len_d;
        out_byte_q   <= res_byte;
        out_unsup_q  <= wsfd_pkg::is_unsupported(opcode_d);
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(wsfd_pkg::OUT_TDATA_W - wsfd_pkg::OUT_FIELDS_W){1'b0}},
                            out_unsup_q, out_byte_q, out_len_q,
                            out_mask_q, out_opcode_q, out_fin_q};

endmodule

>>> bench/tb_websocket_frame_deframer_unit.sv
// Self-checking testbench for the WebSocket frame deframer unit.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_unit;

  // Opcodes the package leaves unnamed
  localparam logic [wsfd_pkg::OPCODE_W-1:0] OP_CONT = 4'h0;

  localparam int unsigned ITEMS_TARGET = 1630;
  localparam int unsigned QUIET_SPAN   = 250;
  localparam int unsigned LONG_HOLD    = 64;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned PAUSE_AT     = 900;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PARSE_HDR0, PARSE_HDR1, PARSE_EXT_LEN, PARSE_KEY, PARSE_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic                          kind;
    logic                          fin;
    logic [wsfd_pkg::OPCODE_W-1:0] opcode;
    logic                          masked;
    logic [wsfd_pkg::PLEN_W-1:0]   plen;
    logic [wsfd_pkg::BYTE_W-1:0]   pbyte;
    logic                          last;
    logic                          unsup;
  } ws_result_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    ws_result_t exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [wsfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;

  websocket_frame_deframer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Byte sender state; the result queue, mismatch count and stall controls are shared with the result checker
  ws_result_t    pending_results[$];
  stim_row_t     directed_rows[$];
  logic [7:0]    frame_bytes[$];
  int unsigned   mismatch_cnt  = 0;
  int unsigned   n_sent        = 0;
  int unsigned   gap_odds      = 0;
  int unsigned   stall_odds    = 0;
  bit            quiet         = 1'b0;
  bit            long_hold_req = 1'b0;

  // Predictor frame state
  parse_phase_e                  ph;
  logic [wsfd_pkg::HCNT_W-1:0]   hdr_left;
  logic                          cur_fin;
  logic [wsfd_pkg::OPCODE_W-1:0] cur_op;
  logic                          cur_masked;
  logic [wsfd_pkg::PLEN_W-1:0]   cur_len;
  logic [wsfd_pkg::KEY_W-1:0]    cur_key;
  logic [wsfd_pkg::PLEN_W-1:0]   pay_left;
  logic [1:0]                    key_idx;

  function automatic ws_result_t mk_res(input logic kind, input logic fin,
                                        input logic [wsfd_pkg::OPCODE_W-1:0] op,
                                        input logic masked,
                                        input logic [wsfd_pkg::PLEN_W-1:0] len,
                                        input logic [wsfd_pkg::BYTE_W-1:0] pb,
                                        input logic last, input logic unsup);
    ws_result_t r;
    r.kind   = kind;
    r.fin    = fin;
    r.opcode = op;
    r.masked = masked;
    r.plen   = len;
    r.pbyte  = pb;
    r.last   = last;
    r.unsup  = unsup;
    return r;
  endfunction

  function automatic ws_result_t frame_result(input logic kind, input logic [7:0] pb,
                                              input logic last);
    logic known_op;
    known_op = (cur_op == wsfd_pkg::OP_TEXT) || (cur_op == wsfd_pkg::OP_BINARY) ||
               (cur_op == wsfd_pkg::OP_CLOSE) || (cur_op == wsfd_pkg::OP_PING);
    return mk_res(kind, cur_fin, cur_op, cur_masked, cur_len, pb, last, !known_op);
  endfunction

  // Header complete: clamp length, load payload counter, emit header result
  function automatic bit close_header(output ws_result_t r);
    if (cur_len > wsfd_pkg::LEN_MAX)
      cur_len = wsfd_pkg::LEN_MAX;
    pay_left = cur_len;
    key_idx  = '0;
    hdr_left = '0;
    r  = frame_result(wsfd_pkg::KIND_HEADER, 8'h00, cur_len == '0);
    ph = (cur_len == '0) ? PARSE_HDR0 : PARSE_PAYLOAD;
    return 1'b1;
  endfunction

  // Length known: a masked frame still needs its key
  function automatic bit close_length(output ws_result_t r);
    if (cur_masked) begin
      ph       = PARSE_KEY;
      hdr_left = wsfd_pkg::KEY_BYTES;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  // Advance the parser by one stream byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output ws_result_t r);
    logic [6:0] len7;
    logic [7:0] kb;
    bit got;
    got = 1'b0;
    r   = '0;
    case (ph)
      PARSE_HDR0: begin
        cur_fin    = (b & wsfd_pkg::FIN_BIT) != 0;
        cur_op     = 4'(b & wsfd_pkg::OPCODE_MASK);
        cur_masked = 1'b0;
        cur_key    = '0;
        cur_len    = '0;
        ph         = PARSE_HDR1;
      end
      PARSE_HDR1: begin
        len7       = 7'(b & wsfd_pkg::LEN7_MASK);
        cur_masked = (b & wsfd_pkg::MASK_BIT) != 0;
        cur_len    = '0;
        if (len7 == wsfd_pkg::LEN7_EXT16 || len7 == wsfd_pkg::LEN7_EXT64) begin
          hdr_left = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                    : wsfd_pkg::EXT64_BYTES;
          ph       = PARSE_EXT_LEN;
        end else begin
          cur_len = 64'(len7);
          got     = close_length(r);
        end
      end
      PARSE_EXT_LEN: begin
        cur_len = {cur_len[wsfd_pkg::PLEN_W-9:0], b};
        if (hdr_left != 0)
          hdr_left = hdr_left - 1'b1;
        if (hdr_left == 0)
          got = close_length(r);
      end
      PARSE_KEY: begin
        cur_key = {cur_key[wsfd_pkg::KEY_W-9:0], b};
        if (hdr_left != 0)
          hdr_left = hdr_left - 1'b1;
        if (hdr_left == 0)
          got = close_header(r);
      end
      PARSE_PAYLOAD: begin
        kb      = 8'(cur_key >> (24 - 8 * key_idx));
        key_idx = key_idx + 1'b1;
        if (pay_left != 0)
          pay_left = pay_left - 1'b1;
        r   = frame_result(wsfd_pkg::KIND_PAYLOAD, b ^ kb, pay_left == 0);
        got = 1'b1;
        if (pay_left == 0)
          ph = PARSE_HDR0;
      end
      default: ph = PARSE_HDR0;
    endcase
    return got;
  endfunction

  // Append helpers for the shared queues
  task automatic add_frame_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  task automatic add_expected(input ws_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic add_row(input logic [7:0] b);
    stim_row_t row;
    row.b     = b;
    row.typed = 1'b0;
    row.exp   = '0;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_typed(input logic [7:0] b, input ws_result_t exp);
    stim_row_t row;
    row.b     = b;
    row.typed = 1'b1;
    row.exp   = exp;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offer one byte, wait for the transfer, then queue its expected result
  task automatic send_byte(input logic [7:0] b, input bit typed, input ws_result_t exp);
    ws_result_t r;
    bit got;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o)
      @(posedge clk_i);
    n_sent++;
    got = parse_byte(b, r);
    if (typed)
      add_expected(exp);
    else if (got)
      add_expected(r);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // One random well-formed frame into frame_bytes
  task automatic build_frame();
    logic [wsfd_pkg::OPCODE_W-1:0] op;
    logic [2:0]          rsv;
    logic                fin_b;
    logic                mask_b;
    logic [63:0]         plen_v;
    logic [31:0]         key_v;
    int unsigned         pick;
    bit                  wide64;
    frame_bytes.delete();
    case ($urandom_range(0, 9))
      0, 1:    op = wsfd_pkg::OP_TEXT;
      2, 3:    op = wsfd_pkg::OP_BINARY;
      4:       op = wsfd_pkg::OP_CLOSE;
      5, 6:    op = wsfd_pkg::OP_PING;
      default: op = 4'($urandom_range(0, 15));
    endcase
    fin_b  = 1'($urandom_range(0, 1));
    rsv    = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
    mask_b = 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 19);
    wide64 = 1'($urandom_range(0, 1));
    if (pick <= 13)      plen_v = 64'($urandom_range(1, 12));
    else if (pick <= 15) plen_v = '0;
    else if (pick <= 17) plen_v = 64'($urandom_range(13, 125));
    else if (pick == 18) plen_v = 64'($urandom_range(126, 300));
    else                 plen_v = 64'($urandom_range(0, 40));
    add_frame_byte({fin_b, rsv, op});
    // Length field: 7-bit, or 16/64-bit extended (also non-minimal encodings)
    if (plen_v >= 126 || (pick == 19 && !wide64)) begin
      add_frame_byte({mask_b, wsfd_pkg::LEN7_EXT16});
      add_frame_byte(plen_v[15:8]);
      add_frame_byte(plen_v[7:0]);
    end else if (pick == 19) begin
      add_frame_byte({mask_b, wsfd_pkg::LEN7_EXT64});
      for (int i = 7; i >= 0; i--)
        add_frame_byte(8'(plen_v >> (8 * i)));
    end else begin
      add_frame_byte({mask_b, 7'(plen_v)});
    end
    if (mask_b) begin
      key_v = $urandom;
      for (int i = 3; i >= 0; i--)
        add_frame_byte(8'(key_v >> (8 * i)));
    end
    repeat (int'(plen_v)) add_frame_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, name, exp_v, got_v);
    end
  endtask

  // Reset, directed table, random frames, end of run
  initial begin : byte_sender
    bit hold_done;
    bit pause_done;
    logic [31:0] key_v;
    hold_done       = 1'b0;
    pause_done      = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    ph         = PARSE_HDR0;
    hdr_left   = '0;
    cur_fin    = 1'b0;
    cur_op     = '0;
    cur_masked = 1'b0;
    cur_len    = '0;
    cur_key    = '0;
    pay_left   = '0;
    key_idx    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty text frame: header result is the last one
    add_row(8'h81);
    add_typed(8'h00, mk_res(wsfd_pkg::KIND_HEADER, 1'b1, wsfd_pkg::OP_TEXT, 1'b0, 64'd0,
                            8'h00, 1'b1, 1'b0));
    // Masked close with one byte: 0x5A ^ key byte 0xFF
    add_row(8'h88);
    add_row(8'h81);
    add_row(8'hFF);
    add_row(8'h00);
    add_row(8'hA5);
    add_typed(8'h5A, mk_res(wsfd_pkg::KIND_HEADER, 1'b1, wsfd_pkg::OP_CLOSE, 1'b1, 64'd1,
                            8'h00, 1'b0, 1'b0));
    add_typed(8'h5A, mk_res(wsfd_pkg::KIND_PAYLOAD, 1'b1, wsfd_pkg::OP_CLOSE, 1'b1, 64'd1,
                            8'hA5, 1'b1, 1'b0));
    // Binary fragment with RSV bits set, 16-bit length of 2, unmasked
    add_row(8'h72);
    add_row(8'h7E);
    add_row(8'h00);
    add_typed(8'h02, mk_res(wsfd_pkg::KIND_HEADER, 1'b0, wsfd_pkg::OP_BINARY, 1'b0, 64'd2,
                            8'h00, 1'b0, 1'b0));
    add_row(8'hFF);
    add_row(8'h00);
    // Continuation (unsupported) with a 64-bit length of zero
    add_row(8'h80);
    add_row(8'h7F);
    repeat (7) add_row(8'h00);
    add_typed(8'h00, mk_res(wsfd_pkg::KIND_HEADER, 1'b1, OP_CONT, 1'b0, 64'd0,
                            8'h00, 1'b1, 1'b1));
    // Empty ping
    add_row(8'h89);
    add_typed(8'h00, mk_res(wsfd_pkg::KIND_HEADER, 1'b1, wsfd_pkg::OP_PING, 1'b0, 64'd0,
                            8'h00, 1'b1, 1'b0));

    gap_odds   = 3;
    stall_odds = 3;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].exp);

    // Random frames
    while (n_sent < ITEMS_TARGET) begin
      build_frame();
      gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      if (!hold_done && n_sent >= HOLD_AT) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!pause_done && n_sent >= PAUSE_AT) begin
        s_axis_tvalid_i <= 1'b0;
        while (pending_results.size() != 0)
          @(posedge clk_i);
        pause_done = 1'b1;
      end
      quiet = (n_sent + QUIET_SPAN >= ITEMS_TARGET);
      send_frame();
    end

    // Maximal 64-bit length, masked; the stream ends inside its payload
    frame_bytes.delete();
    add_frame_byte({1'b1, 3'b000, wsfd_pkg::OP_BINARY});
    add_frame_byte({1'b1, wsfd_pkg::LEN7_EXT64});
    repeat (8) add_frame_byte(8'hFF);
    key_v = $urandom;
    for (int i = 3; i >= 0; i--)
      add_frame_byte(8'(key_v >> (8 * i)));
    repeat (6) add_frame_byte(8'($urandom_range(0, 255)));
    send_frame();
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("websocket_frame_deframer_unit regression: pass");
    else
      $display("websocket_frame_deframer_unit regression: fail");
    $finish;
  end

  // Result side: check each transfer, drive tready with random stalls
  initial begin : result_checker
    ws_result_t want;
    ws_result_t seen;
    int unsigned stall_left;
    stall_left      = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen.kind   = m_axis_tuser_o;
        seen.fin    = m_axis_tdata_o[0];
        seen.opcode = m_axis_tdata_o[4:1];
        seen.masked = m_axis_tdata_o[5];
        seen.plen   = m_axis_tdata_o[69:6];
        seen.pbyte  = m_axis_tdata_o[77:70];
        seen.unsup  = m_axis_tdata_o[78];
        seen.last   = m_axis_tlast_o;
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result, got 'h%0h", $time, seen);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(seen.kind));
          check_field("fin", 64'(want.fin), 64'(seen.fin));
          check_field("opcode", 64'(want.opcode), 64'(seen.opcode));
          check_field("masked", 64'(want.masked), 64'(seen.masked));
          check_field("payload_length", want.plen, seen.plen);
          check_field("payload_byte", 64'(want.pbyte), 64'(seen.pbyte));
          check_field("last", 64'(want.last), 64'(seen.last));
          check_field("unsupported", 64'(want.unsup), 64'(seen.unsup));
        end
      end
      // Stall control: one long hold on request, else short random bursts
      if (stall_left == 0 && !quiet) begin
        if (long_hold_req) begin
          stall_left    = LONG_HOLD;
          long_hold_req = 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
          stall_left = $urandom_range(1, 4);
        end
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("websocket_frame_deframer_unit regression: fail");
    $finish;
  end

endmodule
